>>> sv/fba_pkg.sv
// shared constants, types and helpers for the frame bitmap allocator
package fba_pkg;

    localparam int MAX_FRAMES  = 65536;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W      = $clog2(WORD_COUNT);
    localparam int CNT_W       = $clog2(WORD_COUNT + 1);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int FRAME_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int OUT_LIMIT   = 65536;
    localparam int FRAME_LIMIT = (MAX_FRAMES < OUT_LIMIT) ? MAX_FRAMES : OUT_LIMIT;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(65536);
    localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

    typedef enum logic [1:0] {
        STATUS_DONE          = 2'd0,
        STATUS_SKIPPED       = 2'd1,
        STATUS_OUT_OF_FRAMES = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_FOUND,
        ST_FREE_WR,
        ST_RESULT
    } state_t;

    // index of the lowest clear bit, zero when none is clear
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> sv/fba_ram.sv
// generic simple dual-port ram with registered read
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/frame_bitmap_allocator.sv
// first-fit physical frame allocator over a used/free bitmap held in ram
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  input     | s_valid / s_ready  | s_operation s_current_frame s_kernel_page s_writeable
//  result    | m_valid / m_ready  | m_new_frame m_present_bit m_write_bit m_user_bit m_status
//  config    | cfg_wr_en          | cfg_wr_data (frame_count)
//
//  skipped requests and frees of never-used words go straight to the result; other frees
//  read and rewrite their word; an allocation scans bitmap words in order (up to 2048) until
//  one has a free bit or the last is reached, bounded by the one-word-per-cycle ram read port
//  no clearing pass after reset: a fill mark makes never-written words read as free
//  one request in flight; a finished result waits in the output register while the next
//  transfer is accepted, and a result stalls only when that register is full and m_ready is low
module frame_bitmap_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [fba_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [fba_pkg::FRAME_W-1:0] s_current_frame,
    input  logic                        s_kernel_page,
    input  logic                        s_writeable,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fba_pkg::FRAME_W-1:0] m_new_frame,
    output logic                        m_present_bit,
    output logic                        m_write_bit,
    output logic                        m_user_bit,
    output logic [1:0]                  m_status
);

    fba_pkg::state_t                state_reg, state_next;
    logic [fba_pkg::COUNT_W-1:0]    frame_count_reg;
    logic [fba_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic [fba_pkg::ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [fba_pkg::WORD_BITS-1:0]  word_reg, word_next;
    logic [fba_pkg::ADDR_W-1:0]     idx_reg, idx_next;

    fba_pkg::op_t                   op_reg;
    logic [fba_pkg::FRAME_W-1:0]    cur_reg;
    logic                           kern_reg;
    logic                           wr_reg;

    logic [fba_pkg::FRAME_W-1:0]    res_frame_reg, res_frame_next;
    logic                           res_present_reg, res_present_next;
    fba_pkg::status_t               res_status_reg, res_status_next;

    logic                           m_valid_reg;
    logic [fba_pkg::FRAME_W-1:0]    m_new_frame_reg;
    logic                           m_present_reg;
    logic                           m_write_reg;
    logic                           m_user_reg;
    fba_pkg::status_t               m_status_reg;

    logic                           mem_wr_en;
    logic [fba_pkg::ADDR_W-1:0]     mem_wr_addr;
    logic [fba_pkg::WORD_BITS-1:0]  mem_wr_data;
    logic [fba_pkg::WORD_BITS-1:0]  mem_rd_data;

    logic [fba_pkg::COUNT_W-1:0]    usable;
    logic [fba_pkg::CNT_W-1:0]      words;
    logic [fba_pkg::WORD_BITS-1:0]  scan_word;
    logic [fba_pkg::ADDR_W-1:0]     cur_word;
    logic [fba_pkg::BIT_W-1:0]      cur_bit;
    logic [fba_pkg::BIT_W-1:0]      found_bit;
    logic                           out_free;
    logic                           cur_in_range;

    fba_ram #(
        .WIDTH(fba_pkg::WORD_BITS),
        .DEPTH(fba_pkg::WORD_COUNT)
    ) u_bitmap (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_addr(rd_addr_next),
        .rd_data(mem_rd_data)
    );

    assign usable = (32'(frame_count_reg) > fba_pkg::FRAME_LIMIT)
                  ? fba_pkg::COUNT_W'(fba_pkg::FRAME_LIMIT) : frame_count_reg;
    assign words  = fba_pkg::CNT_W'(usable >> fba_pkg::BIT_W);

    // words at or above the fill mark were never written and hold no used frames
    assign scan_word = ({1'b0, rd_addr_reg} < fill_reg) ? mem_rd_data : '0;

    assign cur_word     = fba_pkg::ADDR_W'(cur_reg >> fba_pkg::BIT_W);
    assign cur_bit      = cur_reg[fba_pkg::BIT_W-1:0];
    assign cur_in_range = (32'(cur_reg) < fba_pkg::MAX_FRAMES);
    assign found_bit    = fba_pkg::lowest_zero(word_reg);
    assign out_free     = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == fba_pkg::ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        rd_addr_next     = rd_addr_reg;
        word_next        = word_reg;
        idx_next         = idx_reg;
        res_frame_next   = res_frame_reg;
        res_present_next = res_present_reg;
        res_status_next  = res_status_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = rd_addr_reg;
        mem_wr_data      = mem_rd_data;

        case (state_reg)
            fba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fba_pkg::ST_DISPATCH;
                end
            end
            fba_pkg::ST_DISPATCH: begin
                res_present_next = 1'b0;
                res_frame_next   = '0;
                res_status_next  = fba_pkg::STATUS_DONE;
                state_next       = fba_pkg::ST_RESULT;
                if (op_reg == fba_pkg::OP_ALLOC) begin
                    if (cur_reg != '0) begin
                        res_frame_next  = cur_reg;
                        res_status_next = fba_pkg::STATUS_SKIPPED;
                    end else if (words == '0) begin
                        res_status_next = fba_pkg::STATUS_OUT_OF_FRAMES;
                    end else begin
                        rd_addr_next = '0;
                        state_next   = fba_pkg::ST_SCAN;
                    end
                end else begin
                    if (cur_reg == '0) begin
                        res_status_next = fba_pkg::STATUS_SKIPPED;
                    end else if (cur_in_range && ({1'b0, cur_word} < fill_reg)) begin
                        rd_addr_next = cur_word;
                        state_next   = fba_pkg::ST_FREE_WR;
                    end
                end
            end
            fba_pkg::ST_SCAN: begin
                if (scan_word != fba_pkg::FULL_WORD) begin
                    word_next  = scan_word;
                    idx_next   = rd_addr_reg;
                    state_next = fba_pkg::ST_FOUND;
                end else if (fba_pkg::CNT_W'(rd_addr_reg) + 1'b1 == words) begin
                    res_status_next = fba_pkg::STATUS_OUT_OF_FRAMES;
                    state_next      = fba_pkg::ST_RESULT;
                end else begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
            end
            fba_pkg::ST_FOUND: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg;
                mem_wr_data = word_reg | (fba_pkg::WORD_BITS'(1) << found_bit);
                if ({1'b0, idx_reg} >= fill_reg) begin
                    fill_next = fba_pkg::CNT_W'(idx_reg) + 1'b1;
                end
                res_frame_next   = (fba_pkg::FRAME_W'(idx_reg) << fba_pkg::BIT_W)
                                 | fba_pkg::FRAME_W'(found_bit);
                res_present_next = 1'b1;
                res_status_next  = fba_pkg::STATUS_DONE;
                state_next       = fba_pkg::ST_RESULT;
            end
            fba_pkg::ST_FREE_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = rd_addr_reg;
                mem_wr_data = mem_rd_data & ~(fba_pkg::WORD_BITS'(1) << cur_bit);
                state_next  = fba_pkg::ST_RESULT;
            end
            fba_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fba_pkg::ST_IDLE;
            frame_count_reg <= fba_pkg::COUNT_RESET;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_wr_en) begin
                frame_count_reg <= cfg_wr_data;
            end
            if (state_reg == fba_pkg::ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg     <= rd_addr_next;
        word_reg        <= word_next;
        idx_reg         <= idx_next;
        res_frame_reg   <= res_frame_next;
        res_present_reg <= res_present_next;
        res_status_reg  <= res_status_next;
        if (s_valid && s_ready) begin
            op_reg   <= fba_pkg::op_t'(s_operation);
            cur_reg  <= s_current_frame;
            kern_reg <= s_kernel_page;
            wr_reg   <= s_writeable;
        end
        if (state_reg == fba_pkg::ST_RESULT && out_free) begin
            m_new_frame_reg <= res_frame_reg;
            m_present_reg   <= res_present_reg;
            m_write_reg     <= res_present_reg & wr_reg;
            m_user_reg      <= res_present_reg & ~kern_reg;
            m_status_reg    <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_new_frame   = m_new_frame_reg;
    assign m_present_bit = m_present_reg;
    assign m_write_bit   = m_write_reg;
    assign m_user_bit    = m_user_reg;
    assign m_status      = m_status_reg;

    // bitmap is written only when claiming or releasing a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == fba_pkg::ST_FOUND || state_reg == fba_pkg::ST_FREE_WR))
        else $error("bitmap write outside claim or release");

    // a word picked by the scan always has a free bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fba_pkg::ST_FOUND |-> word_reg != fba_pkg::FULL_WORD)
        else $error("scan picked a full word");

    // fill mark grows by at most one word per write and never shrinks
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != $past(fill_reg) |->
            (fill_reg == $past(fill_reg) + 1'b1 && $past(state_reg) == fba_pkg::ST_FOUND))
        else $error("fill mark moved unexpectedly");

    // fill mark stays within the bitmap
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= fba_pkg::WORD_COUNT)
        else $error("fill mark beyond bitmap");

    // a new result is loaded only into an empty or draining output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_new_frame_reg))
        else $error("pending result overwritten");

endmodule

>>> bench/frame_bitmap_allocator_test.sv
// self-checking bench for frame_bitmap_allocator: directed table, then random requests
`timescale 1ns / 1ps
module frame_bitmap_allocator_test;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 39;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        fba_pkg::op_t                op;
        logic [fba_pkg::FRAME_W-1:0] frame;
        logic                        kernel;
        logic                        writeable;
    } request_t;

    typedef struct {
        logic [fba_pkg::FRAME_W-1:0] frame;
        logic                        present;
        logic                        write_bit;
        logic                        user_bit;
        fba_pkg::status_t            status;
    } grant_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_COUNT
    } row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [fba_pkg::COUNT_W-1:0] count;
        request_t                    req;
        bit                          known;
        grant_t                      want;
    } row_t;

    logic                         aclk;
    logic                         aresetn         = 1'b0;
    logic                         cfg_wr_en       = 1'b0;
    logic [fba_pkg::COUNT_W-1:0]  cfg_wr_data     = '0;
    logic                         s_valid         = 1'b0;
    logic                         s_operation     = 1'b0;
    logic [fba_pkg::FRAME_W-1:0]  s_current_frame = '0;
    logic                         s_kernel_page   = 1'b0;
    logic                         s_writeable     = 1'b0;
    logic                         m_ready         = 1'b0;
    logic                         s_ready;
    logic                         m_valid;
    logic [fba_pkg::FRAME_W-1:0]  m_new_frame;
    logic                         m_present_bit;
    logic                         m_write_bit;
    logic                         m_user_bit;
    logic [1:0]                   m_status;

    logic [fba_pkg::WORD_BITS-1:0] frame_used [fba_pkg::WORD_COUNT];
    int                            frame_limit;
    grant_t                        predicted_grants [$];
    row_t                          plan [$];
    grant_t                        seen;
    int                            errors     = 0;
    int                            cycles     = 0;
    int                            sink_hold  = 0;
    bit                            quiet_src  = 1'b0;
    bit                            quiet_sink = 1'b0;

    frame_bitmap_allocator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_current_frame (s_current_frame),
        .s_kernel_page   (s_kernel_page),
        .s_writeable     (s_writeable),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_frame     (m_new_frame),
        .m_present_bit   (m_present_bit),
        .m_write_bit     (m_write_bit),
        .m_user_bit      (m_user_bit),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // first-fit search over whole words below the saturated frame count
    function automatic grant_t predict_grant(request_t q);
        grant_t g;
        int limit, words, found, w, b, fi;
        g.frame     = '0;
        g.present   = 1'b0;
        g.write_bit = 1'b0;
        g.user_bit  = 1'b0;
        g.status    = fba_pkg::STATUS_DONE;
        if (q.op == fba_pkg::OP_ALLOC) begin
            if (q.frame != '0) begin
                g.frame  = q.frame;
                g.status = fba_pkg::STATUS_SKIPPED;
            end else begin
                limit = frame_limit;
                if (limit > fba_pkg::MAX_FRAMES) limit = fba_pkg::MAX_FRAMES;
                if (limit > fba_pkg::OUT_LIMIT) limit = fba_pkg::OUT_LIMIT;
                words = limit / fba_pkg::WORD_BITS;
                found = -1;
                for (w = 0; w < words && w < fba_pkg::WORD_COUNT && found < 0; w++) begin
                    if (frame_used[w] != fba_pkg::FULL_WORD) begin
                        for (b = fba_pkg::WORD_BITS - 1; b >= 0; b--) begin
                            if (!frame_used[w][b]) found = w * fba_pkg::WORD_BITS + b;
                        end
                    end
                end
                if (found < 0) begin
                    g.status = fba_pkg::STATUS_OUT_OF_FRAMES;
                end else begin
                    frame_used[found / fba_pkg::WORD_BITS][found % fba_pkg::WORD_BITS] = 1'b1;
                    g.frame     = fba_pkg::FRAME_W'(found);
                    g.present   = 1'b1;
                    g.write_bit = q.writeable;
                    g.user_bit  = ~q.kernel;
                end
            end
        end else begin
            fi = int'(q.frame);
            if (q.frame == '0) begin
                g.status = fba_pkg::STATUS_SKIPPED;
            end else if (fi < fba_pkg::MAX_FRAMES) begin
                frame_used[fi / fba_pkg::WORD_BITS][fi % fba_pkg::WORD_BITS] = 1'b0;
            end
        end
        return g;
    endfunction

    // mostly empty-entry allocations and frees of low frames, with some noise
    function automatic request_t random_request();
        request_t q;
        int r;
        r = $urandom_range(0, 99);
        q.op        = fba_pkg::OP_ALLOC;
        q.frame     = '0;
        q.kernel    = 1'($urandom_range(0, 1));
        q.writeable = 1'($urandom_range(0, 1));
        if (r >= 60 && r < 68) begin
            q.frame = fba_pkg::FRAME_W'($urandom_range(1, 65535));
        end else if (r >= 68) begin
            q.op = fba_pkg::OP_FREE;
            if (r < 90) q.frame = fba_pkg::FRAME_W'($urandom_range(1, 127));
            else if (r < 95) q.frame = fba_pkg::FRAME_W'($urandom);
        end
        return q;
    endfunction

    function automatic row_t ask(fba_pkg::op_t op, logic [fba_pkg::FRAME_W-1:0] f,
                                 logic k, logic w);
        row_t r;
        r.kind          = ROW_REQUEST;
        r.count         = '0;
        r.req.op        = op;
        r.req.frame     = f;
        r.req.kernel    = k;
        r.req.writeable = w;
        r.known         = 1'b0;
        r.want.frame     = '0;
        r.want.present   = 1'b0;
        r.want.write_bit = 1'b0;
        r.want.user_bit  = 1'b0;
        r.want.status    = fba_pkg::STATUS_DONE;
        return r;
    endfunction

    function automatic row_t ask_want(fba_pkg::op_t op, logic [fba_pkg::FRAME_W-1:0] f,
                                      logic k, logic w,
                                      logic [fba_pkg::FRAME_W-1:0] nf, logic p, logic wb,
                                      logic ub, fba_pkg::status_t st);
        row_t r;
        r = ask(op, f, k, w);
        r.known          = 1'b1;
        r.want.frame     = nf;
        r.want.present   = p;
        r.want.write_bit = wb;
        r.want.user_bit  = ub;
        r.want.status    = st;
        return r;
    endfunction

    function automatic row_t set_count(logic [fba_pkg::COUNT_W-1:0] c);
        row_t r;
        r       = ask(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b0);
        r.kind  = ROW_COUNT;
        r.count = c;
        return r;
    endfunction

    task automatic send_request(request_t q, bit known, grant_t want);
        grant_t g;
        int gap;
        s_valid         <= 1'b1;
        s_operation     <= q.op;
        s_current_frame <= q.frame;
        s_kernel_page   <= q.kernel;
        s_writeable     <= q.writeable;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        g = predict_grant(q);
        if (known) predicted_grants.push_back(want);
        else predicted_grants.push_back(g);
        gap = quiet_src ? 0 : gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // block is idle once every grant is back, so the count can change
    task automatic write_count(logic [fba_pkg::COUNT_W-1:0] c);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_grants.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        frame_limit  = int'(c);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (!quiet_sink && $urandom_range(0, 3) == 0) sink_hold = gap_length();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_grants.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding, %s %0h status %0d",
                         $time, "expected none got frame", m_new_frame, m_status);
                errors++;
            end else begin
                seen = predicted_grants.pop_front();
                check_field("new_frame", seen.frame, m_new_frame);
                check_field("present_bit", seen.present, m_present_bit);
                check_field("write_bit", seen.write_bit, m_write_bit);
                check_field("user_bit", seen.user_bit, m_user_bit);
                check_field("status", seen.status, m_status);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("frame_bitmap_allocator_test: errors");
            $finish;
        end
    end

    initial begin : stimulus
        row_t                        r;
        int                          ph, n;
        logic [fba_pkg::COUNT_W-1:0] sweep [RANDOM_PHASES];
        for (int i = 0; i < fba_pkg::WORD_COUNT; i++) frame_used[i] = '0;
        frame_limit = int'(fba_pkg::COUNT_RESET);

        plan.push_back(ask_want(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b1,
                                16'd0, 1'b1, 1'b1, 1'b1, fba_pkg::STATUS_DONE));
        plan.push_back(ask_want(fba_pkg::OP_ALLOC, '0, 1'b1, 1'b0,
                                16'd1, 1'b1, 1'b0, 1'b0, fba_pkg::STATUS_DONE));
        plan.push_back(ask_want(fba_pkg::OP_ALLOC, 16'hFFFF, 1'b1, 1'b1,
                                16'hFFFF, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_SKIPPED));
        plan.push_back(ask_want(fba_pkg::OP_FREE, '0, 1'b1, 1'b1,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_SKIPPED));
        plan.push_back(ask_want(fba_pkg::OP_FREE, 16'hFFFF, 1'b0, 1'b0,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_DONE));
        plan.push_back(ask_want(fba_pkg::OP_FREE, 16'd1, 1'b1, 1'b0,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_DONE));
        plan.push_back(ask(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b0));
        plan.push_back(set_count('0));
        plan.push_back(ask_want(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b1,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_OUT_OF_FRAMES));
        plan.push_back(ask(fba_pkg::OP_FREE, 16'd1, 1'b0, 1'b1));
        plan.push_back(set_count(fba_pkg::COUNT_W'(fba_pkg::WORD_BITS - 1)));
        plan.push_back(ask_want(fba_pkg::OP_ALLOC, '0, 1'b1, 1'b1,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_OUT_OF_FRAMES));
        plan.push_back(set_count(fba_pkg::COUNT_W'(fba_pkg::WORD_BITS)));
        plan.push_back(ask(fba_pkg::OP_ALLOC, '0, 1'b1, 1'b1));
        plan.push_back(ask(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b0));
        plan.push_back(ask_want(fba_pkg::OP_FREE, 16'd2, 1'b0, 1'b0,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_DONE));
        plan.push_back(set_count('1));
        plan.push_back(ask(fba_pkg::OP_ALLOC, '0, 1'b1, 1'b0));
        plan.push_back(set_count(fba_pkg::COUNT_W'(40)));
        plan.push_back(ask(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b1));
        plan.push_back(ask_want(fba_pkg::OP_FREE, 16'h8000, 1'b1, 1'b1,
                                16'd0, 1'b0, 1'b0, 1'b0, fba_pkg::STATUS_DONE));
        plan.push_back(set_count(fba_pkg::COUNT_RESET));

        sweep[0] = fba_pkg::COUNT_W'(64);
        sweep[1] = fba_pkg::COUNT_W'(100);
        sweep[2] = '1;
        sweep[3] = '0;
        sweep[4] = fba_pkg::COUNT_W'(fba_pkg::WORD_BITS);
        sweep[5] = fba_pkg::COUNT_W'($urandom_range(33, 160));
        sweep[6] = fba_pkg::COUNT_RESET;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_COUNT) write_count(r.count);
            else send_request(r.req, r.known, r.want);
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_count(sweep[ph]);
            quiet_src  = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = ask(fba_pkg::OP_ALLOC, '0, 1'b0, 1'b0);
                send_request(random_request(), 1'b0, r.want);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("frame_bitmap_allocator_test: clean");
        end else begin
            $display("frame_bitmap_allocator_test: errors");
        end
        $finish;
    end

endmodule
